// ===== sv/tle_pkg.sv =====
package tle_pkg;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_D  = 8'h44;
    localparam logic [7:0] CH_NUL      = 8'h00;

    localparam logic [7:0] CAPACITY_RESET = 8'd64;
    localparam logic [7:0] LENGTH_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SEEN,
        ESC_BRACKET
    } esc_phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_BS,
        KIND_LF
    } burst_kind_t;

    typedef enum logic [1:0] {
        STEP_FIRST,
        STEP_SECOND,
        STEP_THIRD
    } burst_step_t;

    // One edited input byte, as handed from the editor to the echo sequencer.
    typedef struct packed {
        burst_kind_t kind;
        logic [7:0]  ch;
        logic        store;
        logic [7:0]  index;
        logic        too_long;
    } burst_t;

endpackage

// ===== sv/tle_editor.sv =====
module tle_editor
    import tle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_fire,
    input  logic [7:0] line_capacity,
    output logic       has_result,
    output burst_t     desc
);

    esc_phase_t phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] ch;
    logic       swallowed;

    always_comb
    begin
        ch = rx_byte;
        if (ch == CH_DEL)
        begin
            ch = CH_BS;
        end
        else if (ch == CH_CR)
        begin
            ch = CH_LF;
        end

        phase_next = phase_reg;
        swallowed  = 1'b0;
        if (ch == CH_ESC)
        begin
            phase_next = ESC_SEEN;
            swallowed  = 1'b1;
        end
        else
        begin
            case (phase_reg)
                ESC_IDLE:
                begin
                    phase_next = ESC_IDLE;
                end
                ESC_SEEN:
                begin
                    if (ch == CH_LBRACKET)
                    begin
                        phase_next = ESC_BRACKET;
                        swallowed  = 1'b1;
                    end
                    else
                    begin
                        phase_next = ESC_IDLE;
                    end
                end
                ESC_BRACKET:
                begin
                    // Cursor keys end the sequence silently; anything else is typed.
                    phase_next = ESC_IDLE;
                    swallowed  = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_D);
                end
                default:
                begin
                    phase_next = ESC_IDLE;
                end
            endcase
        end

        length_next   = length_reg;
        has_result    = 1'b0;
        desc.kind     = KIND_CHAR;
        desc.ch       = ch;
        desc.store    = 1'b0;
        desc.index    = 8'd0;
        desc.too_long = 1'b0;

        if (!swallowed)
        begin
            if (ch == CH_LF)
            begin
                has_result    = 1'b1;
                desc.kind     = KIND_LF;
                desc.store    = length_reg < line_capacity;
                desc.index    = desc.store ? length_reg : 8'd0;
                desc.too_long = !desc.store;
                length_next   = 8'd0;
            end
            else if (ch == CH_BS)
            begin
                if (length_reg != 8'd0)
                begin
                    has_result  = 1'b1;
                    desc.kind   = KIND_BS;
                    length_next = length_reg - 8'd1;
                end
            end
            else
            begin
                has_result  = 1'b1;
                desc.kind   = KIND_CHAR;
                desc.store  = ({1'b0, length_reg} + 9'd1) < {1'b0, line_capacity};
                desc.index  = desc.store ? length_reg : 8'd0;
                length_next = (length_reg == LENGTH_MAX) ? length_reg : length_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ESC_IDLE;
            length_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
        end
    end

endmodule

// ===== sv/tle_sequencer.sv =====
module tle_sequencer
    import tle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  burst_t     push_desc,
    output logic       push_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       line_done,
    output logic       line_too_long,
    output logic       last
);

    burst_t      pend_reg, cur_reg;
    logic        pend_valid_reg, pend_valid_next;
    logic        cur_valid_reg, cur_valid_next;
    burst_step_t step_reg, step_next;
    logic        step_last;
    logic        cur_free;
    logic        pop;

    always_comb
    begin
        case (cur_reg.kind)
            KIND_CHAR: step_last = 1'b1;
            KIND_BS:   step_last = (step_reg == STEP_THIRD);
            KIND_LF:   step_last = (step_reg == STEP_SECOND);
            default:   step_last = 1'b1;
        endcase
    end

    // The current burst frees up in the same cycle its final transfer completes.
    assign cur_free   = !cur_valid_reg || (out_ready && step_last);
    assign pop        = pend_valid_reg && cur_free;
    assign push_ready = !pend_valid_reg || cur_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (push)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pop)
        begin
            pend_valid_next = 1'b0;
        end

        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (cur_free)
        begin
            cur_valid_next = pend_valid_reg;
            step_next      = STEP_FIRST;
        end
        else if (out_ready)
        begin
            case (step_reg)
                STEP_FIRST:  step_next = STEP_SECOND;
                STEP_SECOND: step_next = STEP_THIRD;
                default:     step_next = STEP_THIRD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            step_reg       <= STEP_FIRST;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            cur_valid_reg  <= cur_valid_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pend_reg <= push_desc;
        end
        if (pop)
        begin
            cur_reg <= pend_reg;
        end
    end

    always_comb
    begin
        out_valid     = cur_valid_reg;
        echo_valid    = 1'b1;
        echo_byte     = cur_reg.ch;
        store_valid   = 1'b0;
        store_index   = 8'd0;
        store_byte    = CH_NUL;
        line_done     = 1'b0;
        line_too_long = 1'b0;
        last          = step_last;
        case (cur_reg.kind)
            KIND_CHAR:
            begin
                echo_byte   = cur_reg.ch;
                store_valid = cur_reg.store;
                store_index = cur_reg.index;
                store_byte  = cur_reg.store ? cur_reg.ch : CH_NUL;
            end
            KIND_BS:
            begin
                echo_byte = (step_reg == STEP_SECOND) ? CH_SP : CH_BS;
            end
            KIND_LF:
            begin
                if (step_reg == STEP_FIRST)
                begin
                    echo_byte     = CH_LF;
                    store_valid   = cur_reg.store;
                    store_index   = cur_reg.index;
                    line_done     = 1'b1;
                    line_too_long = cur_reg.too_long;
                end
                else
                begin
                    echo_byte = CH_CR;
                end
            end
            default:
            begin
                echo_byte = cur_reg.ch;
            end
        endcase
    end

endmodule

// ===== sv/terminal_line_editor.sv =====
// Terminal line editor: cooked-mode editing of bytes received from a serial link.
// The input channel (in_valid, in_ready, rx_byte) takes one received byte per transfer.
// DEL is treated as backspace and CR as LF; ESC [ A..D cursor sequences are dropped.
// Each byte yields zero to three results on the output channel (out_valid, out_ready):
// an echo byte, an optional write into the external line store, and line status.
// The flag last marks the final result caused by one input byte.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes line_capacity,
// the store size including the terminator; write it only while the block is idle.
// The byte passes through the pending and then the current burst register before its
// first result is shown on the output.
// A byte with no result never reaches the output; results leave one per cycle while
// the receiver holds out_ready high, so the output port sets the rate.
// A pending-burst register sits between the editor and the output sequencer, so a new
// byte is taken while the previous burst still waits on a stalled receiver.
// When the receiver stalls, the current result holds and input stops once both
// the pending and the current burst registers are full.
// Reset clears the line length, the escape tracking and both buffers, and sets
// line_capacity to 64.
module terminal_line_editor
    import tle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       line_done,
    output logic       line_too_long,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] line_capacity_reg;
    logic       in_fire;
    logic       has_result;
    burst_t     desc;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            line_capacity_reg <= cfg_data;
        end
    end

    tle_editor u_editor (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .in_fire       (in_fire),
        .line_capacity (line_capacity_reg),
        .has_result    (has_result),
        .desc          (desc)
    );

    tle_sequencer u_sequencer (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (in_fire && has_result),
        .push_desc     (desc),
        .push_ready    (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_valid    (echo_valid),
        .echo_byte     (echo_byte),
        .store_valid   (store_valid),
        .store_index   (store_index),
        .store_byte    (store_byte),
        .line_done     (line_done),
        .line_too_long (line_too_long),
        .last          (last)
    );

    // An overflowed line never writes its terminator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_too_long) |-> (line_done && !store_valid))
        else $error("too-long line also wrote the store");

    // The end-of-line result is the LF echo and is always followed by CR.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_done) |-> (echo_byte == CH_LF && !last))
        else $error("line end result is malformed");

    // A burst is never cut short: after a non-final transfer another result follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("result burst broken off before its last transfer");

endmodule
